>>> rtl/alarm_tone_pattern_sequencer_unit_macros.svh
// Assertion macros shared by the checker of the alarm tone pattern sequencer.
`ifndef ALARM_TONE_PATTERN_SEQUENCER_UNIT_MACROS_SVH
`define ALARM_TONE_PATTERN_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off while arst_n is low.
`define ATPS_CHECK(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and switched off while arst_n is low.
`define ATPS_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/atps_pkg.sv
// Package with the beat types, register codes and reset values of the tone sequencer.
`timescale 1ns / 1ps
`default_nettype none
package atps_pkg;

	typedef struct packed {
		logic        kind;
		logic [31:0] now_ms;
		logic [1:0]  new_mode;
	} in_item_t;

	typedef struct packed {
		logic        tone_enable;
		logic [15:0] tone_freq;
	} out_item_t;

	typedef struct packed {
		logic [15:0] warn_on_time;
		logic [15:0] warn_off_time;
		logic [15:0] crit_continuous_time;
		logic [15:0] crit_on_time;
		logic [15:0] crit_off_time;
		logic [15:0] warn_freq;
		logic [15:0] crit_freq;
	} atps_cfg_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] mode_start;
		logic [31:0] last_toggle;
		logic        pattern_on;
		logic        continuous_done;
		logic        drive_on;
		logic        freq_is_critical;
	} atps_state_t;

	// Beat kinds.
	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_MODE = 1'b1;

	// Mode codes.
	localparam logic [1:0] MODE_SILENT = 2'd0;
	localparam logic [1:0] MODE_WARN   = 2'd1;
	localparam logic [1:0] MODE_CRIT   = 2'd2;

	// Register indexes.
	localparam int unsigned CFG_INDEX_W = 3;
	localparam logic [CFG_INDEX_W-1:0] REG_WARN_ON   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_WARN_OFF  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_CRIT_CONT = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_CRIT_ON   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_CRIT_OFF  = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_WARN_FREQ = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_CRIT_FREQ = 3'd6;

	// Register reset values.
	localparam logic [15:0] RST_WARN_ON   = 16'd500;
	localparam logic [15:0] RST_WARN_OFF  = 16'd1000;
	localparam logic [15:0] RST_CRIT_CONT = 16'd2000;
	localparam logic [15:0] RST_CRIT_ON   = 16'd300;
	localparam logic [15:0] RST_CRIT_OFF  = 16'd300;
	localparam logic [15:0] RST_WARN_FREQ = 16'd500;
	localparam logic [15:0] RST_CRIT_FREQ = 16'd2000;

endpackage
`default_nettype wire

>>> rtl/alarm_tone_pattern_sequencer_unit.sv
// Top level of the alarm tone pattern sequencer. Every request beat is either a mode change
// (silent, warning or critical) or a tick carrying the current time in milliseconds, and
// every request beat yields exactly one response beat with the tone enable flag and the tone
// frequency in hertz. A beat is taken into an input register, passes through the pattern
// logic, which updates the mode and timing state, and lands in an output register; its
// response is offered on the cycle after the one in which it leaves the input register,
// which it does once the output register is empty or its response is being taken.
// The block takes one beat every cycle for as long as the response side keeps up, and the
// input register fills behind a stalled output register, so one beat waits there while a
// finished response is held. Elapsed times are 32-bit wrapping differences against the
// latched start and last toggle times; a tick at time zero leaves the start unlatched.
// The user writes the seven timing and frequency registers through the cfg port only while
// no beat is in flight, unenforced by the block; the frequency follows them as they stand.
`timescale 1ns / 1ps
`default_nettype none
module alarm_tone_pattern_sequencer_unit
	import atps_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   req_valid,
	output logic                        req_ready,
	input  wire in_item_t               req_data,
	output logic                        rsp_valid,
	input  wire logic                   rsp_ready,
	output out_item_t                   rsp_data,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [15:0]            cfg_wdata
);

	// Input register stage.
	logic     valid_s1;
	in_item_t item_s1;

	// Output register stage.
	logic      valid_s2;
	out_item_t result_s2;

	atps_cfg_t cfg;
	out_item_t result;
	logic      advance;

	// The beat in the input register moves on whenever the output register is empty or
	// its response is being taken in this cycle; the state update happens at that edge.
	assign advance   = valid_s1 && (!valid_s2 || rsp_ready);
	assign req_ready = !valid_s1 || advance;

	atps_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	atps_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (rsp_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Payload registers carry no reset; the valid flags qualify them.
	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			item_s1 <= req_data;
		end
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp_data  = result_s2;

endmodule
`default_nettype wire

>>> rtl/atps_cfg_regs.sv
// Configuration register file of the tone sequencer.
`timescale 1ns / 1ps
`default_nettype none
module atps_cfg_regs
	import atps_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [15:0]            cfg_wdata,
	output atps_cfg_t                   cfg
);

	atps_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.warn_on_time         <= RST_WARN_ON;
			cfg_q.warn_off_time        <= RST_WARN_OFF;
			cfg_q.crit_continuous_time <= RST_CRIT_CONT;
			cfg_q.crit_on_time         <= RST_CRIT_ON;
			cfg_q.crit_off_time        <= RST_CRIT_OFF;
			cfg_q.warn_freq            <= RST_WARN_FREQ;
			cfg_q.crit_freq            <= RST_CRIT_FREQ;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WARN_ON: begin
					cfg_q.warn_on_time <= cfg_wdata;
				end
				REG_WARN_OFF: begin
					cfg_q.warn_off_time <= cfg_wdata;
				end
				REG_CRIT_CONT: begin
					cfg_q.crit_continuous_time <= cfg_wdata;
				end
				REG_CRIT_ON: begin
					cfg_q.crit_on_time <= cfg_wdata;
				end
				REG_CRIT_OFF: begin
					cfg_q.crit_off_time <= cfg_wdata;
				end
				REG_WARN_FREQ: begin
					cfg_q.warn_freq <= cfg_wdata;
				end
				REG_CRIT_FREQ: begin
					cfg_q.crit_freq <= cfg_wdata;
				end
				default: begin
					// Writes to unused indexes are dropped.
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

>>> rtl/atps_core.sv
// Pattern state registers and the single-pass next-state logic of the tone sequencer.
`timescale 1ns / 1ps
`default_nettype none
module atps_core
	import atps_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      step,
	input  wire in_item_t  item,
	input  wire atps_cfg_t cfg,
	output out_item_t      result
);

	atps_state_t cur_q;
	atps_state_t nxt;

	always_comb begin
		logic [31:0] gone;
		logic [31:0] total;
		logic [31:0] on_len;
		logic [31:0] off_len;
		logic        is_crit;
		logic        do_blink;

		nxt      = cur_q;
		gone     = '0;
		total    = '0;
		do_blink = 1'b0;
		is_crit  = (cur_q.mode == MODE_CRIT);
		on_len   = is_crit ? {16'd0, cfg.crit_on_time}  : {16'd0, cfg.warn_on_time};
		off_len  = is_crit ? {16'd0, cfg.crit_off_time} : {16'd0, cfg.warn_off_time};

		if (item.kind == KIND_MODE) begin
			if (item.new_mode != cur_q.mode) begin
				nxt.mode            = item.new_mode;
				nxt.mode_start      = '0;
				nxt.last_toggle     = '0;
				nxt.pattern_on      = 1'b0;
				nxt.continuous_done = 1'b0;
				if (item.new_mode == MODE_SILENT) begin
					nxt.drive_on = 1'b0;
				end
			end
		end else begin
			// A zero start time means the start has not been latched yet.
			if (cur_q.mode_start == '0) begin
				nxt.mode_start  = item.now_ms;
				nxt.last_toggle = item.now_ms;
			end
			gone  = item.now_ms - nxt.last_toggle;
			total = item.now_ms - nxt.mode_start;

			case (cur_q.mode)
				MODE_WARN: begin
					do_blink = 1'b1;
				end
				MODE_CRIT: begin
					if (!cur_q.continuous_done) begin
						if (total == '0) begin
							nxt.drive_on         = 1'b1;
							nxt.freq_is_critical = 1'b1;
						end
						if (total >= {16'd0, cfg.crit_continuous_time}) begin
							nxt.continuous_done = 1'b1;
							nxt.last_toggle     = item.now_ms;
							nxt.pattern_on      = 1'b0;
							nxt.drive_on        = 1'b0;
						end
					end else begin
						do_blink = 1'b1;
					end
				end
				default: begin
					nxt.drive_on = 1'b0;
				end
			endcase

			if (do_blink) begin
				if (cur_q.pattern_on) begin
					if (gone >= on_len) begin
						nxt.pattern_on  = 1'b0;
						nxt.last_toggle = item.now_ms;
						nxt.drive_on    = 1'b0;
					end
				end else if (gone >= off_len) begin
					nxt.pattern_on       = 1'b1;
					nxt.last_toggle      = item.now_ms;
					nxt.drive_on         = 1'b1;
					nxt.freq_is_critical = is_crit;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (step) begin
			cur_q <= nxt;
		end
	end

	assign result.tone_enable = nxt.drive_on;
	assign result.tone_freq   = nxt.freq_is_critical ? cfg.crit_freq : cfg.warn_freq;

endmodule
`default_nettype wire

>>> rtl/atps_checker.sv
// Port-level checker of the tone sequencer and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "alarm_tone_pattern_sequencer_unit_macros.svh"
module atps_checker
	import atps_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   req_valid,
	input wire logic                   req_ready,
	input wire in_item_t               req_data,
	input wire logic                   rsp_valid,
	input wire logic                   rsp_ready,
	input wire out_item_t              rsp_data,
	input wire logic                   cfg_we,
	input wire logic [CFG_INDEX_W-1:0] cfg_index,
	input wire logic [15:0]            cfg_wdata
);

	// Shadow copies of the two frequency registers, kept from the write port.
	logic [15:0] warn_freq_q;
	logic [15:0] crit_freq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warn_freq_q <= RST_WARN_FREQ;
			crit_freq_q <= RST_CRIT_FREQ;
		end else if (cfg_we) begin
			if (cfg_index == REG_WARN_FREQ) begin
				warn_freq_q <= cfg_wdata;
			end
			if (cfg_index == REG_CRIT_FREQ) begin
				crit_freq_q <= cfg_wdata;
			end
		end
	end

	// A held response beat keeps its payload.
	`ATPS_CHECK_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "response beat changed while stalled")

	// Requests are refused only while a response is waiting on the other side.
	`ATPS_CHECK(a_backpressure, !req_ready, rsp_valid && !rsp_ready, "request refused without a stalled response")

	// The reported frequency is always one of the two programmed frequencies.
	`ATPS_CHECK(a_freq_source, rsp_valid, rsp_data.tone_freq == warn_freq_q || rsp_data.tone_freq == crit_freq_q, "tone frequency is not a programmed value")

	// No response comes out of reset.
	`ATPS_CHECK(a_reset_empty, $rose(arst_n), !rsp_valid, "response valid right after reset")

endmodule

bind alarm_tone_pattern_sequencer_unit atps_checker u_atps_checker (.*);
`default_nettype wire
